>>> sv/sse_pkg.sv
// Package for the server-sent events stream parser: payload types, command and
// status codes, sequencer states and the byte constants of the stream format.
// No dependencies.
package sse_pkg;

    // Default sizes of the line store (and type store) and of the data store.
    localparam int LINE_BYTES_DEF = 1024;
    localparam int DATA_BYTES_DEF = 4096;

    // Command codes.
    localparam logic [1:0] CMD_FEED      = 2'd0;
    localparam logic [1:0] CMD_READ_DATA = 2'd1;
    localparam logic [1:0] CMD_READ_TYPE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LINE_LONG = 2'd1;
    localparam logic [1:0] ST_DATA_LONG = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    // Stream characters.
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Byte order mark length.
    localparam logic [1:0] MARK_LEN = 2'd3;

    // Field name lengths.
    localparam int EVENT_LEN = 5;
    localparam int DATA_LEN  = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  byte_in;
        logic [11:0] read_index;
    } t_req;

    typedef struct packed {
        logic        event_ready;
        logic [10:0] type_length;
        logic [12:0] data_length;
        logic [7:0]  read_byte;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_REPLAY,
        S_FEED,
        S_COPY_RD,
        S_COPY_WR,
        S_NEWLINE,
        S_READ
    } t_state;

    // Bytes of the byte order mark, EF BB BF.
    function automatic logic [7:0] mark_byte(input logic [1:0] k);
        case (k)
            2'd0:    mark_byte = 8'hef;
            2'd1:    mark_byte = 8'hbb;
            default: mark_byte = 8'hbf;
        endcase
    endfunction

    // Characters of the field name "event".
    function automatic logic [7:0] event_char(input logic [2:0] k);
        case (k)
            3'd0:    event_char = 8'h65;
            3'd1:    event_char = 8'h76;
            3'd2:    event_char = 8'h65;
            3'd3:    event_char = 8'h6e;
            default: event_char = 8'h74;
        endcase
    endfunction

    // Characters of the field name "data".
    function automatic logic [7:0] data_char(input logic [1:0] k);
        case (k)
            2'd0:    data_char = 8'h64;
            2'd1:    data_char = 8'h61;
            2'd2:    data_char = 8'h74;
            default: data_char = 8'h61;
        endcase
    endfunction

endpackage

>>> sv/sse_chan_if.sv
// Valid/ready channel carrying one request or result payload.
// Depends on nothing; the payload type is given by the user.
interface sse_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/sse_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> sv/sse_event_stream_parser_core.sv
// Top level of the server-sent events stream parser.
// Uses sse_pkg, sse_chan_if and three sse_ram instances.

// Each request is either a stream byte to feed or a read of a buffered data or
// type byte, and each gives exactly one result. An ordinary stream byte passes
// the start and feed steps, a read the start and read steps, and a byte that
// extends a partial byte order mark only the start step. A line end that has
// an "event" or "data" value copies the value from the line store into its
// buffer through one line store read port, a read and a write step per value
// byte plus a closing read step, and a newline step for a data line; a broken
// partial byte order mark adds a replay step per held mark byte. Requests are
// taken only while the sequencer is idle and the result register is free.
module sse_event_stream_parser_core #(
    parameter int LINE_BYTES = sse_pkg::LINE_BYTES_DEF,
    parameter int DATA_BYTES = sse_pkg::DATA_BYTES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sse_chan_if.sink   i_req,
    sse_chan_if.source o_rsp
);
    localparam int LW  = $clog2(LINE_BYTES);
    localparam int LCW = $clog2(LINE_BYTES + 1);
    localparam int DW  = $clog2(DATA_BYTES);
    localparam int DCW = $clog2(DATA_BYTES + 1);
    localparam int SW  = ((DCW > LCW) ? DCW : LCW) + 1;

    sse_pkg::t_state r_state, n_state;

    logic [1:0]     r_cmd;
    logic [7:0]     r_byte;
    logic [11:0]    r_idx;
    logic [LCW-1:0] r_line_count, n_line_count;
    logic [DCW-1:0] r_data_count, n_data_count;
    logic [LCW-1:0] r_type_count, n_type_count;
    logic           r_seen, n_seen;
    logic           r_after_cr, n_after_cr;
    logic           r_failed, n_failed;
    logic           r_mark_done, n_mark_done;
    logic [1:0]     r_mark_held, n_mark_held;
    logic [1:0]     r_mk, n_mk;
    logic [1:0]     r_mk_n, n_mk_n;
    logic [7:0]     r_first, n_first;
    logic           r_colon_found, n_colon_found;
    logic [LCW-1:0] r_colon_pos, n_colon_pos;
    logic           r_space, n_space;
    logic           r_ev_ok, n_ev_ok;
    logic           r_da_ok, n_da_ok;
    logic [LCW-1:0] r_src, n_src;
    logic [LCW-1:0] r_left, n_left;
    logic [SW-1:0]  r_dst, n_dst;
    logic           r_to_data, n_to_data;
    logic           r_out_valid, n_out_valid;
    sse_pkg::t_rsp  r_out, n_out;

    logic           w_accept;
    logic [1:0]     w_h;
    logic           w_mark_hit;
    logic           w_is_lf;
    logic           w_is_cr;
    logic           w_end;
    logic           w_full;
    logic [LCW-1:0] w_colon;
    logic [LCW-1:0] w_vs1;
    logic [LCW-1:0] w_vs;
    logic [LCW-1:0] w_vl;
    logic           w_ev_match;
    logic           w_da_match;
    logic           w_over;
    logic [7:0]     w_ap_byte;
    logic           w_ap_do;

    logic           w_line_we;
    logic           w_data_we;
    logic           w_type_we;
    logic [7:0]     w_data_wdata;
    logic [7:0]     w_line_rdata;
    logic [7:0]     w_data_rdata;
    logic [7:0]     w_type_rdata;

    // Handshake: one request at a time, the result register must be free.
    assign i_req.ready = (r_state == sse_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Decode of the latched byte and of the line being assembled.
    assign w_h        = (r_mark_held < sse_pkg::MARK_LEN) ? r_mark_held : 2'd0;
    assign w_mark_hit = (r_byte == sse_pkg::mark_byte(w_h));
    assign w_is_lf    = (r_byte == sse_pkg::CH_LF);
    assign w_is_cr    = (r_byte == sse_pkg::CH_CR);
    assign w_end      = (w_is_lf && !r_after_cr) || w_is_cr;
    assign w_full     = (r_line_count >= LCW'(LINE_BYTES));
    assign w_colon    = r_colon_found ? r_colon_pos : r_line_count;
    assign w_vs1      = w_colon + LCW'(1);
    assign w_vs       = !r_colon_found ? r_line_count :
                        ((w_vs1 < r_line_count) && r_space) ? w_vs1 + LCW'(1) : w_vs1;
    assign w_vl       = r_line_count - w_vs;
    assign w_ev_match = r_ev_ok && (w_colon == LCW'(sse_pkg::EVENT_LEN));
    assign w_da_match = r_da_ok && (w_colon == LCW'(sse_pkg::DATA_LEN));
    assign w_over     = (SW'(r_data_count) + SW'(w_vl) + SW'(1)) > SW'(DATA_BYTES);
    assign w_ap_byte  = (r_state == sse_pkg::S_REPLAY) ? sse_pkg::mark_byte(r_mk) : r_byte;
    assign w_ap_do    = (r_state == sse_pkg::S_REPLAY) ||
                        ((r_state == sse_pkg::S_FEED) && !w_is_lf && !w_is_cr);

    // Memory write controls.
    assign w_line_we    = w_ap_do && !w_full;
    assign w_type_we    = (r_state == sse_pkg::S_COPY_WR) && !r_to_data;
    assign w_data_we    = ((r_state == sse_pkg::S_COPY_WR) && r_to_data) ||
                          (r_state == sse_pkg::S_NEWLINE);
    assign w_data_wdata = (r_state == sse_pkg::S_NEWLINE) ? sse_pkg::CH_LF : w_line_rdata;

    sse_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r_line_count[LW-1:0]),
        .i_wdata (w_ap_byte),
        .i_raddr (r_src[LW-1:0]),
        .o_rdata (w_line_rdata)
    );

    sse_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (DW'(r_dst)),
        .i_wdata (w_data_wdata),
        .i_raddr (DW'(r_idx)),
        .o_rdata (w_data_rdata)
    );

    sse_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_type_ram (
        .i_clk   (i_clk),
        .i_we    (w_type_we),
        .i_waddr (LW'(r_dst)),
        .i_wdata (w_line_rdata),
        .i_raddr (LW'(r_idx)),
        .o_rdata (w_type_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sse_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sse_pkg::S_START;
                end
            end
            sse_pkg::S_START: begin
                unique case (r_cmd) inside
                    sse_pkg::CMD_FEED: begin
                        if (r_failed) begin
                            n_state = sse_pkg::S_IDLE;
                        end else if (r_mark_done) begin
                            n_state = sse_pkg::S_FEED;
                        end else if (w_mark_hit) begin
                            n_state = sse_pkg::S_IDLE;
                        end else if (w_h != 2'd0) begin
                            n_state = sse_pkg::S_REPLAY;
                        end else begin
                            n_state = sse_pkg::S_FEED;
                        end
                    end
                    sse_pkg::CMD_READ_DATA, sse_pkg::CMD_READ_TYPE: n_state = sse_pkg::S_READ;
                    default: n_state = sse_pkg::S_IDLE;
                endcase
            end
            sse_pkg::S_REPLAY: begin
                if (w_full) begin
                    n_state = sse_pkg::S_IDLE;
                end else if (r_mk + 2'd1 == r_mk_n) begin
                    n_state = sse_pkg::S_FEED;
                end
            end
            sse_pkg::S_FEED: begin
                n_state = sse_pkg::S_IDLE;
                if (w_end && (r_line_count != '0) && (r_first != sse_pkg::CH_COLON)) begin
                    if (w_ev_match || (w_da_match && !w_over)) begin
                        n_state = sse_pkg::S_COPY_RD;
                    end
                end
            end
            sse_pkg::S_COPY_RD: begin
                if (r_left != '0) begin
                    n_state = sse_pkg::S_COPY_WR;
                end else if (r_to_data) begin
                    n_state = sse_pkg::S_NEWLINE;
                end else begin
                    n_state = sse_pkg::S_IDLE;
                end
            end
            sse_pkg::S_COPY_WR: n_state = sse_pkg::S_COPY_RD;
            sse_pkg::S_NEWLINE: n_state = sse_pkg::S_IDLE;
            sse_pkg::S_READ:    n_state = sse_pkg::S_IDLE;
            default:            n_state = sse_pkg::S_IDLE;
        endcase
    end

    // Datapath and result updates for each sequencer step.
    always_comb begin
        n_line_count  = r_line_count;
        n_data_count  = r_data_count;
        n_type_count  = r_type_count;
        n_seen        = r_seen;
        n_after_cr    = r_after_cr;
        n_failed      = r_failed;
        n_mark_done   = r_mark_done;
        n_mark_held   = r_mark_held;
        n_mk          = r_mk;
        n_mk_n        = r_mk_n;
        n_first       = r_first;
        n_colon_found = r_colon_found;
        n_colon_pos   = r_colon_pos;
        n_space       = r_space;
        n_ev_ok       = r_ev_ok;
        n_da_ok       = r_da_ok;
        n_src         = r_src;
        n_left        = r_left;
        n_dst         = r_dst;
        n_to_data     = r_to_data;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out         = r_out;

        // A new request clears the result fields it does not set.
        if (w_accept) begin
            n_out = '0;
        end

        // Appending one byte to the line and tracking its name and value.
        if (w_ap_do) begin
            if (w_full) begin
                n_failed       = 1'b1;
                n_out.status   = sse_pkg::ST_LINE_LONG;
                n_out_valid    = 1'b1;
            end else begin
                n_line_count = r_line_count + LCW'(1);
                if (r_line_count == '0) begin
                    n_first = w_ap_byte;
                end
                if (!r_colon_found) begin
                    if (w_ap_byte == sse_pkg::CH_COLON) begin
                        n_colon_found = 1'b1;
                        n_colon_pos   = r_line_count;
                    end else begin
                        if (r_line_count < LCW'(sse_pkg::EVENT_LEN)) begin
                            n_ev_ok = r_ev_ok &&
                                (w_ap_byte == sse_pkg::event_char(3'(r_line_count)));
                        end else begin
                            n_ev_ok = 1'b0;
                        end
                        if (r_line_count < LCW'(sse_pkg::DATA_LEN)) begin
                            n_da_ok = r_da_ok &&
                                (w_ap_byte == sse_pkg::data_char(2'(r_line_count)));
                        end else begin
                            n_da_ok = 1'b0;
                        end
                    end
                end else if (r_line_count == r_colon_pos + LCW'(1)) begin
                    n_space = (w_ap_byte == sse_pkg::CH_SPACE);
                end
            end
        end

        unique case (r_state)
            sse_pkg::S_START: begin
                unique case (r_cmd) inside
                    sse_pkg::CMD_FEED: begin
                        if (r_failed) begin
                            n_out.status = sse_pkg::ST_REFUSED;
                            n_out_valid  = 1'b1;
                        end else if (!r_mark_done) begin
                            if (w_mark_hit) begin
                                if (w_h + 2'd1 == sse_pkg::MARK_LEN) begin
                                    n_mark_held = 2'd0;
                                    n_mark_done = 1'b1;
                                end else begin
                                    n_mark_held = w_h + 2'd1;
                                end
                                n_out_valid = 1'b1;
                            end else begin
                                n_mk        = 2'd0;
                                n_mk_n      = w_h;
                                n_mark_held = 2'd0;
                                n_mark_done = 1'b1;
                            end
                        end
                    end
                    sse_pkg::CMD_READ_DATA, sse_pkg::CMD_READ_TYPE: begin
                    end
                    default: n_out_valid = 1'b1;
                endcase
            end
            sse_pkg::S_REPLAY: begin
                n_mk = r_mk + 2'd1;
            end
            sse_pkg::S_FEED: begin
                if (w_is_lf || w_is_cr) begin
                    n_after_cr = w_is_cr;
                end else begin
                    n_after_cr = 1'b0;
                end
                if (!w_ap_do) begin
                    n_out_valid = 1'b1;
                end else if (!w_full) begin
                    n_out_valid = 1'b1;
                end
                if (w_end) begin
                    if (r_line_count == '0) begin
                        // Blank line: dispatch when data was seen.
                        if (r_seen) begin
                            n_out.event_ready = 1'b1;
                            n_out.type_length = 11'(r_type_count);
                            n_out.data_length = 13'(r_data_count - DCW'(1));
                        end
                        n_type_count = '0;
                        n_data_count = '0;
                        n_seen       = 1'b0;
                    end else begin
                        n_line_count  = '0;
                        n_first       = '0;
                        n_colon_found = 1'b0;
                        n_colon_pos   = '0;
                        n_space       = 1'b0;
                        n_ev_ok       = 1'b1;
                        n_da_ok       = 1'b1;
                        n_src         = w_vs;
                        n_left        = w_vl;
                        if (r_first != sse_pkg::CH_COLON) begin
                            if (w_ev_match) begin
                                n_type_count = w_vl;
                                n_dst        = '0;
                                n_to_data    = 1'b0;
                                n_out_valid  = 1'b0;
                            end else if (w_da_match) begin
                                if (w_over) begin
                                    n_failed     = 1'b1;
                                    n_out.status = sse_pkg::ST_DATA_LONG;
                                end else begin
                                    n_dst       = SW'(r_data_count);
                                    n_to_data   = 1'b1;
                                    n_out_valid = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            sse_pkg::S_COPY_RD: begin
                if (r_left != '0) begin
                    n_src = r_src + LCW'(1);
                end else if (!r_to_data) begin
                    n_out_valid = 1'b1;
                end
            end
            sse_pkg::S_COPY_WR: begin
                n_dst  = r_dst + SW'(1);
                n_left = r_left - LCW'(1);
            end
            sse_pkg::S_NEWLINE: begin
                n_data_count = DCW'(r_dst + SW'(1));
                n_seen       = 1'b1;
                n_out_valid  = 1'b1;
            end
            sse_pkg::S_READ: begin
                if (r_cmd == sse_pkg::CMD_READ_DATA) begin
                    if (int'(r_idx) < DATA_BYTES) begin
                        n_out.read_byte = w_data_rdata;
                    end
                end else if (int'(r_idx) < LINE_BYTES) begin
                    n_out.read_byte = w_type_rdata;
                end
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sse_pkg::S_IDLE;
            r_line_count  <= '0;
            r_data_count  <= '0;
            r_type_count  <= '0;
            r_seen        <= 1'b0;
            r_after_cr    <= 1'b0;
            r_failed      <= 1'b0;
            r_mark_done   <= 1'b0;
            r_mark_held   <= 2'd0;
            r_first       <= '0;
            r_colon_found <= 1'b0;
            r_colon_pos   <= '0;
            r_space       <= 1'b0;
            r_ev_ok       <= 1'b1;
            r_da_ok       <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_line_count  <= n_line_count;
            r_data_count  <= n_data_count;
            r_type_count  <= n_type_count;
            r_seen        <= n_seen;
            r_after_cr    <= n_after_cr;
            r_failed      <= n_failed;
            r_mark_done   <= n_mark_done;
            r_mark_held   <= n_mark_held;
            r_first       <= n_first;
            r_colon_found <= n_colon_found;
            r_colon_pos   <= n_colon_pos;
            r_space       <= n_space;
            r_ev_ok       <= n_ev_ok;
            r_da_ok       <= n_da_ok;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_req.payload.cmd;
            r_byte <= i_req.payload.byte_in;
            r_idx  <= i_req.payload.read_index;
        end
        r_mk      <= n_mk;
        r_mk_n    <= n_mk_n;
        r_src     <= n_src;
        r_left    <= n_left;
        r_dst     <= n_dst;
        r_to_data <= n_to_data;
        r_out     <= n_out;
    end
endmodule
